### design/nearest_palette_mapper_defines.svh
// assertion macros for the nearest palette mapper
// expects clk and arst_n in the scope where a macro is used
`ifndef NEAREST_PALETTE_MAPPER_DEFINES_SVH
`define NEAREST_PALETTE_MAPPER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define NPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define NPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/npm_pkg.sv
// shared types and constants of the nearest palette mapper
// no dependencies; used by the stream interface instances and the top level
package npm_pkg;

	// command codes of an input item
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_LOAD = 2'd0;
	localparam cmd_t CMD_MAP  = 2'd1;
	localparam cmd_t CMD_READ = 2'd2;

	// configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ENTRY_COUNT   = 2'd0;
	localparam cfg_idx_t CFG_ALPHA_THRESH  = 2'd1;
	localparam cfg_idx_t CFG_TRANSP_INDEX  = 2'd2;

	// configuration reset values
	localparam logic [8:0] ENTRY_COUNT_RST  = 9'd256;
	localparam logic [7:0] ALPHA_THRESH_RST = 8'd10;
	localparam logic [8:0] TRANSP_INDEX_RST = 9'd256;

	// channel order inside packed colour words: alpha, red, green, blue
	localparam int CHANNELS = 4;
	localparam int SUM_W    = 40;
	localparam int COUNT_W  = 32;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] entry;
		logic [7:0] in_alpha;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} in_item_t;

	typedef struct packed {
		logic [8:0] chosen_index;
		logic       is_transparent;
		logic [7:0] mean_alpha;
		logic [7:0] mean_red;
		logic [7:0] mean_green;
		logic [7:0] mean_blue;
	} out_item_t;

	typedef struct packed {
		cfg_idx_t   index;
		logic [8:0] value;
	} cfg_item_t;

endpackage

### design/npm_stream_if.sv
// valid/ready stream channel with a typed payload
// payload type comes from npm_pkg at the point of instantiation
interface npm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/npm_ram.sv
// generic single-write, single-read synchronous ram, registered read
// read data holds while no read is issued; no dependencies
module npm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### design/nearest_palette_mapper.sv
// nearest palette mapper top level: palette search, centroid sums, mean read-out
// depends on npm_pkg, npm_stream_if, npm_ram and nearest_palette_mapper_defines.svh
//
// usage
//  req carries one item per handshake: load an entry, map a pixel or read a mean.
//  rsp returns exactly one item per request, in order. cfg writes entry_count,
//  alpha_threshold and transparent_index; it is always ready. the user must write it
//  only while idle; the block itself does not enforce this. one item is in work at a
//  time; req is ready only when the block is idle. load: writes the entry if it is in
//  range, then finishes. transparent map: finishes without a search. opaque map: the
//  palette ram delivers one entry per cycle of the n clamped entries into a two-stage
//  distance pipeline. read: the shared restoring divider forms eight quotient bits per channel.
//  reset empties all sums and counts at once through per-entry valid bits; the
//  palette itself is undefined until loaded. the result register parts the two
//  sides: a stalled rsp holds its item, and the block finishes the next item
//  but waits for the register to free before passing its result on.
`include "nearest_palette_mapper_defines.svh"

module nearest_palette_mapper #(
	parameter int ENTRIES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	npm_stream_if.sink    req,
	npm_stream_if.source  rsp,
	npm_stream_if.sink    cfg
);
	import npm_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_SEARCH   = 7'b0000010,
		ST_UPD_RD   = 7'b0000100,
		ST_UPD_WR   = 7'b0001000,
		ST_DIV_LOAD = 7'b0010000,
		ST_DIVIDE   = 7'b0100000,
		ST_FINISH   = 7'b1000000
	} state_t;

	typedef logic [CHANNELS-1:0][7:0] colour_t;

	typedef struct packed {
		logic [COUNT_W-1:0]                count;
		logic [CHANNELS-1:0][SUM_W-1:0]    sum;
	} stats_t;

	state_t state_q;

	// configuration registers
	logic [8:0] entry_count_q;
	logic [7:0] alpha_thr_q;
	logic [8:0] transp_idx_q;

	// item and search registers
	colour_t       pix_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] issue_q;
	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;
	logic          sq_vld_s2;
	logic [AW-1:0] idx_s2;
	logic [CHANNELS-1:0][15:0] sq_s2;
	logic [17:0]   best_dist_q;
	logic [AW-1:0] best_q;

	// statistics and divider registers
	logic [ENTRIES-1:0] stat_vld_q;
	logic               stat_hit_q;
	logic [1:0]         ch_q;
	logic [2:0]         bit_q;
	logic [SUM_W-1:0]   rem_q;
	logic [7:0]         quo_q;

	// result staging and output register
	logic [8:0]   res_idx_q;
	logic         res_tr_q;
	colour_t      res_mean_q;
	logic         out_vld_q;
	out_item_t    out_q;

	// combinational nets
	logic          req_fire;
	logic          ent_ok;
	logic [AW-1:0] ent_addr;
	colour_t       pix_in;
	logic          is_transp_in;
	logic [CW-1:0] n_clamp;
	logic          pal_we;
	logic          pal_re;
	colour_t       pal_rdata;
	logic [CHANNELS-1:0][15:0] sq_d;
	logic [17:0]   cand_dist;
	logic          better;
	logic          search_done;
	logic          stat_re;
	logic [AW-1:0] stat_raddr;
	logic          stat_we;
	stats_t        stat_rdata;
	stats_t        base;
	stats_t        upd;
	logic [SUM_W-1:0] div_sum;
	logic [SUM_W-1:0] div_shift;
	logic [SUM_W:0]   trial;
	logic             ge;
	logic [7:0]       quo_next;
	logic             out_free;

	// handshakes
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;
	assign out_free  = !out_vld_q || rsp.ready;

	// request decode
	assign ent_ok       = ({1'b0, req.data.entry} < 9'(ENTRIES));
	assign ent_addr     = req.data.entry[AW-1:0];
	assign pix_in       = {req.data.in_blue, req.data.in_green, req.data.in_red,
		req.data.in_alpha};
	assign is_transp_in = (req.data.in_alpha <= alpha_thr_q);

	// clamp of the searched entry count
	always_comb begin
		if (entry_count_q == 9'd0) begin
			n_clamp = CW'(1);
		end else if (entry_count_q > 9'(ENTRIES)) begin
			n_clamp = CW'(ENTRIES);
		end else begin
			n_clamp = CW'(entry_count_q);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= ENTRY_COUNT_RST;
			alpha_thr_q   <= ALPHA_THRESH_RST;
			transp_idx_q  <= TRANSP_INDEX_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.index)
				CFG_ENTRY_COUNT:  entry_count_q <= cfg.data.value;
				CFG_ALPHA_THRESH: alpha_thr_q   <= cfg.data.value[7:0];
				CFG_TRANSP_INDEX: transp_idx_q  <= cfg.data.value;
				default: ;
			endcase
		end
	end

	// palette memory
	assign pal_we = req_fire && (req.data.cmd == CMD_LOAD) && ent_ok;
	assign pal_re = (state_q == ST_SEARCH) && (issue_q != n_q);

	npm_ram #(
		.WIDTH (CHANNELS * 8),
		.DEPTH (ENTRIES)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (ent_addr),
		.wdata (pix_in),
		.re    (pal_re),
		.raddr (issue_q[AW-1:0]),
		.rdata (pal_rdata)
	);

	// squared channel differences of the entry just read
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			logic [7:0] d;
			d = (pal_rdata[c] >= pix_q[c]) ? (pal_rdata[c] - pix_q[c])
				: (pix_q[c] - pal_rdata[c]);
			sq_d[c] = 16'(d) * 16'(d);
		end
	end

	// distance and running minimum, first entry wins ties
	assign cand_dist = 18'(sq_s2[0]) + 18'(sq_s2[1]) + 18'(sq_s2[2]) + 18'(sq_s2[3]);
	assign better = sq_vld_s2 && ((idx_s2 == '0) || (cand_dist < best_dist_q));
	assign search_done = (state_q == ST_SEARCH) && (issue_q == n_q) && !rd_vld_s1
		&& !sq_vld_s2;

	// statistics memory
	assign stat_re    = (req_fire && (req.data.cmd == CMD_READ) && ent_ok)
		|| (state_q == ST_UPD_RD);
	assign stat_raddr = (state_q == ST_UPD_RD) ? best_q : ent_addr;
	assign base       = stat_hit_q ? stat_rdata : '0;
	assign stat_we    = (state_q == ST_UPD_WR) && (base.count != '1);

	// accumulate the mapped pixel into the winning entry
	always_comb begin
		upd.count = base.count + COUNT_W'(1);
		for (int c = 0; c < CHANNELS; c++) begin
			upd.sum[c] = base.sum[c] + SUM_W'(pix_q[c]);
		end
	end

	npm_ram #(
		.WIDTH ($bits(stats_t)),
		.DEPTH (ENTRIES)
	) u_stat_ram (
		.clk   (clk),
		.we    (stat_we),
		.waddr (best_q),
		.wdata (upd),
		.re    (stat_re),
		.raddr (stat_raddr),
		.rdata (stat_rdata)
	);

	// restoring divider step, quotient known to fit eight bits
	assign div_sum   = base.sum[ch_q];
	assign div_shift = {{(SUM_W - COUNT_W){1'b0}}, base.count} << bit_q;
	assign trial     = {1'b0, rem_q} - {1'b0, div_shift};
	assign ge        = !trial[SUM_W];
	assign quo_next  = {quo_q[6:0], ge};

	// entry valid bits: a cleared bit reads as zero sums and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_vld_q <= '0;
		end else begin
			if (pal_we) begin
				stat_vld_q[ent_addr] <= 1'b0;
			end
			if (stat_we) begin
				stat_vld_q[best_q] <= 1'b1;
			end
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			n_q       <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			sq_vld_s2 <= 1'b0;
			ch_q      <= '0;
			bit_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= pal_re;
			sq_vld_s2 <= rd_vld_s1;
			if (state_q == ST_FINISH && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						case (req.data.cmd)
							CMD_MAP: begin
								if (is_transp_in) begin
									state_q <= ST_FINISH;
								end else begin
									state_q <= ST_SEARCH;
									issue_q <= '0;
									n_q     <= n_clamp;
								end
							end
							CMD_READ: begin
								ch_q    <= '0;
								state_q <= ent_ok ? ST_DIV_LOAD : ST_FINISH;
							end
							default: state_q <= ST_FINISH;
						endcase
					end
				end
				ST_SEARCH: begin
					if (pal_re) begin
						issue_q <= issue_q + CW'(1);
					end
					if (search_done) begin
						state_q <= ST_UPD_RD;
					end
				end
				ST_UPD_RD: state_q <= ST_UPD_WR;
				ST_UPD_WR: state_q <= ST_FINISH;
				ST_DIV_LOAD: begin
					bit_q   <= 3'd7;
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					bit_q <= bit_q - 3'd1;
					if (bit_q == 3'd0) begin
						ch_q    <= ch_q + 2'd1;
						state_q <= (ch_q == 2'd3) ? ST_FINISH : ST_DIV_LOAD;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= issue_q[AW-1:0];
		idx_s2 <= idx_s1;
		sq_s2  <= sq_d;
		if (req_fire) begin
			pix_q      <= pix_in;
			stat_hit_q <= stat_vld_q[ent_addr];
			res_idx_q  <= '0;
			res_tr_q   <= 1'b0;
			res_mean_q <= '0;
			if ((req.data.cmd == CMD_MAP) && is_transp_in) begin
				res_idx_q <= transp_idx_q;
				res_tr_q  <= 1'b1;
			end
		end
		if (better) begin
			best_dist_q <= cand_dist;
			best_q      <= idx_s2;
		end
		if (state_q == ST_UPD_RD) begin
			stat_hit_q <= stat_vld_q[best_q];
		end
		if (state_q == ST_UPD_WR) begin
			res_idx_q <= 9'(best_q);
		end
		if (state_q == ST_DIV_LOAD) begin
			rem_q <= div_sum;
			quo_q <= '0;
		end
		if (state_q == ST_DIVIDE) begin
			if (ge) begin
				rem_q <= trial[SUM_W-1:0];
			end
			quo_q <= quo_next;
			if (bit_q == 3'd0) begin
				res_mean_q[ch_q] <= (base.count == '0) ? 8'd0 : quo_next;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_q.chosen_index   <= res_idx_q;
			out_q.is_transparent <= res_tr_q;
			out_q.mean_alpha     <= res_mean_q[0];
			out_q.mean_red       <= res_mean_q[1];
			out_q.mean_green     <= res_mean_q[2];
			out_q.mean_blue      <= res_mean_q[3];
		end
	end

	// checks on the sequencer and the result register
	`NPM_ASSERT_IMP(a_issue_bound, state_q == ST_SEARCH, issue_q <= n_q, "search ran past entry count")
	`NPM_ASSERT_NEXT(a_finish_loads, (state_q == ST_FINISH) && out_free, out_vld_q && (state_q == ST_IDLE), "finished item not presented")
	`NPM_ASSERT_IMP(a_transp_no_mean, out_vld_q && out_q.is_transparent, (out_q.mean_alpha == 8'd0) && (out_q.mean_red == 8'd0) && (out_q.mean_green == 8'd0) && (out_q.mean_blue == 8'd0), "transparent item carries a mean")

endmodule
